/* sv/swic_pkg.sv */
// Shared widths, datapath command codes and control/status types.
package swic_pkg;

  localparam int MODE_W         = 2;
  localparam int VALUE_W        = 11;
  localparam int COUNT_W        = 19;
  localparam int CELL_W         = 11;
  localparam int TOTAL_W        = 20;
  localparam int RANK_LIMIT_DEF = 1024;

  localparam logic [MODE_W-1:0] MODE_ADD_LEFT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DEL_LEFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_RIGHT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_RIGHT = 2'd3;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD      = 4'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 4'd2;
  localparam logic [OP_W-1:0] OP_QA_START  = 4'd3;
  localparam logic [OP_W-1:0] OP_QB_START  = 4'd4;
  localparam logic [OP_W-1:0] OP_UPD_START = 4'd5;
  localparam logic [OP_W-1:0] OP_QUERY     = 4'd6;
  localparam logic [OP_W-1:0] OP_UPDATE    = 4'd7;
  localparam logic [OP_W-1:0] OP_FINISH    = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic upd_done;
    logic qry_done;
    logic in_range;
    logic remove;
    logic right_end;
    logic out_free;
  } dp_sts_t;

endpackage

/* sv/swic_if.sv */
// Valid/ready channel interfaces for move beats and count beats.
interface swic_in_if;
  import swic_pkg::*;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface swic_out_if;
  import swic_pkg::*;
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] inversion_count;

  modport source (output valid, output inversion_count, input ready);
  modport sink   (input valid, input inversion_count, output ready);
endinterface

/* sv/swic_ram.sv */
// Generic simple dual-port RAM with registered read.
module swic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/swic_datapath.sv */
// Fenwick tree memory, walk pointer, accumulator, running total and result register.
module swic_datapath #(
  parameter int RANK_LIMIT = swic_pkg::RANK_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swic_pkg::dp_cmd_t             cmd,
  output swic_pkg::dp_sts_t             sts,
  input  logic [swic_pkg::MODE_W-1:0]   in_mode,
  input  logic [swic_pkg::VALUE_W-1:0]  in_value,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [swic_pkg::COUNT_W-1:0]  out_count
);
  import swic_pkg::*;

  localparam int AW = $clog2(RANK_LIMIT);
  localparam int PW = $clog2(RANK_LIMIT + 1) + 1;
  localparam logic [PW-1:0] LIMIT_P = PW'(RANK_LIMIT);

  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic               pend_r, pend_nxt;
  logic               sub_r, sub_nxt;
  logic [AW-1:0]      wa_r, wa_nxt;
  logic [TOTAL_W-1:0] acc_r, acc_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  logic [PW-1:0]      low_bit;
  logic [PW-1:0]      val_p;
  logic [CELL_W-1:0]  cell_delta;
  logic               remove, right_end;

  swic_ram #(
    .WIDTH (CELL_W),
    .DEPTH (RANK_LIMIT)
  ) u_tree (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign remove     = mode_r inside {MODE_DEL_LEFT, MODE_DEL_RIGHT};
  assign right_end  = mode_r inside {MODE_ADD_RIGHT, MODE_DEL_RIGHT};
  assign low_bit    = p_r & (~p_r + PW'(1));
  assign val_p      = PW'(value_r);
  assign cell_delta = remove ? {CELL_W{1'b1}} : CELL_W'(1);

  assign sts.clr_done  = (p_r == LIMIT_P - PW'(1));
  assign sts.upd_done  = (p_r > LIMIT_P) && !pend_r;
  assign sts.qry_done  = (p_r == '0) && !pend_r;
  assign sts.in_range  = (value_r != '0) && (32'(value_r) <= RANK_LIMIT);
  assign sts.remove    = remove;
  assign sts.right_end = right_end;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

  always_comb begin
    mode_nxt      = mode_r;
    value_nxt     = value_r;
    p_nxt         = p_r;
    pend_nxt      = pend_r;
    sub_nxt       = sub_r;
    wa_nxt        = wa_r;
    acc_nxt       = acc_r;
    total_nxt     = total_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_count_nxt = out_count_r;
    ram_we        = 1'b0;
    ram_waddr     = wa_r;
    ram_wdata     = ram_rdata + cell_delta;
    ram_re        = 1'b0;
    ram_raddr     = AW'(p_r - PW'(1));
    case (cmd.op)
      OP_LOAD: begin
        mode_nxt  = in_mode;
        value_nxt = in_value;
        acc_nxt   = '0;
      end
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = p_r[AW-1:0];
        ram_wdata = '0;
        p_nxt     = p_r + PW'(1);
      end
      OP_QA_START: begin
        p_nxt    = right_end ? LIMIT_P : val_p - PW'(1);
        sub_nxt  = 1'b0;
        pend_nxt = 1'b0;
      end
      OP_QB_START: begin
        p_nxt    = val_p;
        sub_nxt  = 1'b1;
        pend_nxt = 1'b0;
      end
      OP_UPD_START: begin
        p_nxt    = val_p;
        pend_nxt = 1'b0;
      end
      OP_QUERY: begin
        if (p_r != '0) begin
          ram_re = 1'b1;
          p_nxt  = p_r - low_bit;
        end
        pend_nxt = (p_r != '0);
        if (pend_r) begin
          acc_nxt = sub_r ? acc_r - TOTAL_W'(ram_rdata) : acc_r + TOTAL_W'(ram_rdata);
        end
      end
      OP_UPDATE: begin
        if (p_r <= LIMIT_P) begin
          ram_re = 1'b1;
          p_nxt  = p_r + low_bit;
          wa_nxt = ram_raddr;
        end
        pend_nxt = (p_r <= LIMIT_P);
        if (pend_r) begin
          ram_we = 1'b1;
        end
      end
      OP_FINISH: begin
        total_nxt     = remove ? total_r - acc_r : total_r + acc_r;
        out_valid_nxt = 1'b1;
        out_count_nxt = total_nxt[COUNT_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r         <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p_r         <= p_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r      <= mode_nxt;
    value_r     <= value_nxt;
    sub_r       <= sub_nxt;
    wa_r        <= wa_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

endmodule

/* sv/swic_ctrl.sv */
// Sequencer that orders the clearing pass, tree walks and result hand-off.
module swic_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swic_pkg::dp_sts_t sts,
  output swic_pkg::dp_cmd_t cmd
);
  import swic_pkg::*;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_UPD0 = 4'd3;
  localparam logic [3:0] S_UPD  = 4'd4;
  localparam logic [3:0] S_QA0  = 4'd5;
  localparam logic [3:0] S_QA   = 4'd6;
  localparam logic [3:0] S_QB0  = 4'd7;
  localparam logic [3:0] S_QB   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.in_range) begin
          state_nxt = S_FIN;
        end else if (sts.remove) begin
          state_nxt = S_UPD0;
        end else begin
          state_nxt = S_QA0;
        end
      end
      S_UPD0: begin
        cmd.op    = OP_UPD_START;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.op = OP_UPDATE;
        if (sts.upd_done) begin
          state_nxt = sts.remove ? S_QA0 : S_FIN;
        end
      end
      S_QA0: begin
        cmd.op    = OP_QA_START;
        state_nxt = S_QA;
      end
      S_QA: begin
        cmd.op = OP_QUERY;
        if (sts.qry_done) begin
          if (sts.right_end) begin
            state_nxt = S_QB0;
          end else begin
            state_nxt = sts.remove ? S_FIN : S_UPD0;
          end
        end
      end
      S_QB0: begin
        cmd.op    = OP_QB_START;
        state_nxt = S_QB;
      end
      S_QB: begin
        cmd.op = OP_QUERY;
        if (sts.qry_done) begin
          state_nxt = sts.remove ? S_FIN : S_UPD0;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.op    = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* sv/sliding_window_inversion_counter.sv */
// A move beat is loaded and range-checked, then walks the tree (prefix queries and a point
// update, two queries at the right end) for its count; out-of-range ranks skip the walks.
// Flow: one move at a time; the next beat is taken once the count enters the output
// register, which holds it while the sink stalls.
// Reset: synchronous, active low; then a clearing pass zeroes the tree with in_ch.ready low.
module sliding_window_inversion_counter #(
  parameter int RANK_LIMIT = swic_pkg::RANK_LIMIT_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  swic_in_if.sink           in_ch,
  swic_out_if.source        out_ch
);
  import swic_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  swic_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swic_datapath #(
    .RANK_LIMIT (RANK_LIMIT)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (in_ch.mode),
    .in_value  (in_ch.value),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_count (out_ch.inversion_count)
  );

endmodule

/* sv/swic_checker.sv */
// Port-level checker for the inversion counter and its bind.
module swic_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [swic_pkg::COUNT_W-1:0]  out_count
);
  import swic_pkg::*;

  logic       in_fire, out_fire;
  logic [1:0] pend_r;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_fire) - 2'(out_fire);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_count))
    else $error("count beat dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("channels active right after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("count beat without an accepted move");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> pend_r != 2'd2)
    else $error("move accepted with two moves outstanding");

endmodule

bind sliding_window_inversion_counter swic_checker u_swic_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_count (out_ch.inversion_count)
);

/* sim/tb.sv */
// Testbench for the sliding-window inversion counter: directed moves, then random window walks.
`timescale 1ns / 100ps

module tb;
  import swic_pkg::*;

  localparam int RANKS        = RANK_LIMIT_DEF;
  localparam int RANDOM_MOVES = 1365;
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 700;
  localparam int OPENING_LEN  = 25;

  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [VALUE_W-1:0] value;
    bit                 typed;
    logic [COUNT_W-1:0] count;
  } move_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  swic_in_if  in_ch ();
  swic_out_if out_ch ();

  sliding_window_inversion_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [CELL_W-1:0]  rank_cell [1:RANKS];
  logic [TOTAL_W-1:0] inv_total;
  logic [COUNT_W-1:0] pending_counts [$];
  int errors = 0;
  int accepted_moves = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  move_row_t opening_moves [OPENING_LEN] = '{
    '{MODE_ADD_RIGHT, 11'd1024, 1'b1, 19'd0},
    '{MODE_ADD_RIGHT, 11'd1,    1'b1, 19'd1},
    '{MODE_ADD_LEFT,  11'd0,    1'b1, 19'd1},
    '{MODE_ADD_RIGHT, 11'd2047, 1'b1, 19'd1},
    '{MODE_DEL_LEFT,  11'd1025, 1'b1, 19'd1},
    '{MODE_DEL_RIGHT, 11'd0,    1'b1, 19'd1},
    '{MODE_ADD_LEFT,  11'd1,    1'b1, 19'd1},
    '{MODE_ADD_LEFT,  11'd1024, 1'b0, 19'd0},
    '{MODE_ADD_RIGHT, 11'd682,  1'b0, 19'd0},
    '{MODE_ADD_LEFT,  11'd1365, 1'b0, 19'd0},
    '{MODE_ADD_RIGHT, 11'd512,  1'b0, 19'd0},
    '{MODE_ADD_LEFT,  11'd1023, 1'b0, 19'd0},
    '{MODE_DEL_RIGHT, 11'd512,  1'b0, 19'd0},
    '{MODE_DEL_LEFT,  11'd1023, 1'b0, 19'd0},
    '{MODE_DEL_LEFT,  11'd1024, 1'b0, 19'd0},
    '{MODE_DEL_RIGHT, 11'd682,  1'b0, 19'd0},
    '{MODE_DEL_LEFT,  11'd1,    1'b0, 19'd0},
    '{MODE_DEL_RIGHT, 11'd1,    1'b0, 19'd0},
    '{MODE_DEL_RIGHT, 11'd1024, 1'b0, 19'd0},
    '{MODE_ADD_RIGHT, 11'd5,    1'b1, 19'd0},
    '{MODE_DEL_LEFT,  11'd9,    1'b1, 19'h7FFFF},
    '{MODE_ADD_LEFT,  11'd9,    1'b0, 19'd0},
    '{MODE_DEL_RIGHT, 11'd3,    1'b0, 19'd0},
    '{MODE_ADD_RIGHT, 11'd3,    1'b0, 19'd0},
    '{MODE_DEL_LEFT,  11'd5,    1'b0, 19'd0}
  };

  function automatic logic [TOTAL_W-1:0] rank_prefix(int p);
    logic [TOTAL_W-1:0] sum;
    sum = '0;
    if (p > RANKS) p = RANKS;
    while (p > 0) begin
      sum = sum + TOTAL_W'(rank_cell[p]);
      p = p - (p & -p);
    end
    return sum;
  endfunction

  function automatic void rank_bump(int p, logic [CELL_W-1:0] delta);
    while (p >= 1 && p <= RANKS) begin
      rank_cell[p] = rank_cell[p] + delta;
      p = p + (p & -p);
    end
  endfunction

  function automatic logic [COUNT_W-1:0] apply_move(logic [MODE_W-1:0] m,
                                                     logic [VALUE_W-1:0] v);
    int r;
    r = int'(v);
    if (r >= 1 && r <= RANKS) begin
      case (m)
        MODE_ADD_LEFT: begin
          inv_total = inv_total + rank_prefix(r - 1);
          rank_bump(r, CELL_W'(1));
        end
        MODE_DEL_LEFT: begin
          rank_bump(r, '1);
          inv_total = inv_total - rank_prefix(r - 1);
        end
        MODE_ADD_RIGHT: begin
          inv_total = inv_total + (rank_prefix(RANKS) - rank_prefix(r));
          rank_bump(r, CELL_W'(1));
        end
        MODE_DEL_RIGHT: begin
          rank_bump(r, '1);
          inv_total = inv_total - (rank_prefix(RANKS) - rank_prefix(r));
        end
      endcase
    end
    return inv_total[COUNT_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] draw_rank();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return VALUE_W'(($urandom_range(0, 1) != 0) ? RANKS : 1);
    if (pick < 4) return VALUE_W'($urandom_range(1, 16));
    return VALUE_W'($urandom_range(1, RANKS));
  endfunction

  task automatic report(string what, int want, int got);
    $display("mismatch: %s, expected %0d, got %0d", what, want, got);
    errors++;
  endtask

  task automatic send_move(input logic [MODE_W-1:0] m, input logic [VALUE_W-1:0] v,
                           input bit typed, input logic [COUNT_W-1:0] typed_count,
                           input bit quiet);
    int gap;
    logic [COUNT_W-1:0] predicted;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode  <= m;
    in_ch.value <= v;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = apply_move(m, v);
    pending_counts.push_back(typed ? typed_count : predicted);
    accepted_moves++;
  endtask

  initial begin
    int window [$];
    int span_cap;
    int counted;
    int step;
    int pick;
    bit quiet;
    logic [VALUE_W-1:0] v;
    in_ch.valid <= 1'b0;
    in_ch.mode  <= MODE_ADD_LEFT;
    in_ch.value <= '0;
    for (int i = 1; i <= RANKS; i++) rank_cell[i] = '0;
    inv_total = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening_moves[i])
      send_move(opening_moves[i].mode, opening_moves[i].value, opening_moves[i].typed,
                opening_moves[i].count, 1'b0);

    counted = 0;
    step = 0;
    span_cap = 8;
    while (counted < RANDOM_MOVES) begin
      if (step % 100 == 0)
        span_cap = ($urandom_range(0, 2) == 0) ? $urandom_range(200, 500)
                                              : $urandom_range(2, 60);
      quiet = ((step / 64) % 4) == 3;
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // out-of-range rank: tree and total must hold
        v = ($urandom_range(0, 3) == 0) ? '0 : VALUE_W'($urandom_range(RANKS + 1, 2047));
        send_move(MODE_W'($urandom_range(0, 3)), v, 1'b0, '0, quiet);
      end else if (pick < 7) begin
        // removal that ignores the window contents
        send_move(($urandom_range(0, 1) != 0) ? MODE_DEL_LEFT : MODE_DEL_RIGHT, draw_rank(),
                  1'b0, '0, quiet);
        counted++;
      end else if (window.size() == 0 ||
                   (window.size() < span_cap && $urandom_range(0, 9) < 6)) begin
        v = draw_rank();
        if ($urandom_range(0, 1) != 0) begin
          window.push_front(int'(v));
          send_move(MODE_ADD_LEFT, v, 1'b0, '0, quiet);
        end else begin
          window.push_back(int'(v));
          send_move(MODE_ADD_RIGHT, v, 1'b0, '0, quiet);
        end
        counted++;
      end else begin
        if ($urandom_range(0, 1) != 0)
          send_move(MODE_DEL_LEFT, VALUE_W'(window.pop_front()), 1'b0, '0, quiet);
        else
          send_move(MODE_DEL_RIGHT, VALUE_W'(window.pop_back()), 1'b0, '0, quiet);
        counted++;
      end
      step++;
    end
    in_ch.valid <= 1'b0;

    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    int gap;
    int beats;
    bit quiet;
    logic [COUNT_W-1:0] want;
    out_ch.ready <= 1'b0;
    beats = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      quiet = ((beats / 48) % 4) == 2;
      if (!hold_done && accepted_moves >= HOLD_AFTER) begin
        // hold off long enough for the input side to back up
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
          out_ch.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (pending_counts.size() == 0) begin
        report("count beat with none pending", -1, int'(out_ch.inversion_count));
      end else begin
        want = pending_counts.pop_front();
        if (out_ch.inversion_count !== want)
          report("inversion_count", int'(want), int'(out_ch.inversion_count));
      end
      beats++;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
